@@ hdl/lfrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and constants for the lowest free resource scheduler.
// ----------------------------------------------------------------------------
package lfrs_pkg;

    // number of resources built into the free-time and count tables
    localparam int RESOURCES = 16;
    localparam int IDX_W     = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

    // field widths
    localparam int TIME_IN_W = 32;
    localparam int TIME_W    = 64;
    localparam int COUNT_W   = 32;
    localparam int RES_W     = 6;
    localparam int CFG_W     = 7;

    // reset value of the active resource count register
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // control from the sequencer to the pick unit
    typedef struct packed {
        logic step;   // one free time is presented this cycle
        logic first;  // presented entry is resource zero
    } pick_ctrl_t;

    // running result of the pick unit
    typedef struct packed {
        logic              found;          // some resource free by current time
        logic [IDX_W-1:0]  chosen;         // lowest such resource
        logic [IDX_W-1:0]  earliest_idx;   // resource with earliest free time
        logic [TIME_W-1:0] earliest_time;  // that free time
    } pick_stat_t;

endpackage

@@ hdl/lfrs_pick.sv @@
// ----------------------------------------------------------------------------
// lfrs_pick
// Shared compare unit: takes one free time per step and keeps the lowest
// free resource and the earliest free resource seen so far.
// ----------------------------------------------------------------------------
module lfrs_pick
    import lfrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  pick_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  idx,
    input  logic [TIME_W-1:0] free_time,
    input  logic [TIME_W-1:0] cur_time,
    output pick_stat_t        stat
);

    logic              found_reg;
    logic [IDX_W-1:0]  chosen_reg;
    logic [IDX_W-1:0]  earliest_idx_reg;
    logic [TIME_W-1:0] earliest_time_reg;

    logic hit;
    logic earlier;

    // the two comparisons of one step
    assign hit     = (free_time <= cur_time);
    assign earlier = (free_time < earliest_time_reg);

    // running lowest free and earliest free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctrl.step) begin
            if (ctrl.first) begin
                found_reg         <= hit;
                chosen_reg        <= idx;
                earliest_idx_reg  <= idx;
                earliest_time_reg <= free_time;
            end else begin
                if (!found_reg && hit) begin
                    found_reg  <= 1'b1;
                    chosen_reg <= idx;
                end
                if (earlier) begin
                    earliest_idx_reg  <= idx;
                    earliest_time_reg <= free_time;
                end
            end
        end
    end

    assign stat.found         = found_reg;
    assign stat.chosen        = chosen_reg;
    assign stat.earliest_idx  = earliest_idx_reg;
    assign stat.earliest_time = earliest_time_reg;

endmodule

@@ hdl/lowest_free_resource_scheduler.sv @@
// ----------------------------------------------------------------------------
// lowest_free_resource_scheduler
// List scheduler that gives each job the lowest free resource, or waits for
// the earliest free one, and tracks the most used resource.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one job (requested start, requested end); jobs should
//   come in order of nondecreasing start. Each accepted job gives exactly
//   one result on m_tdata: assigned resource, actual start, finish time,
//   most used resource and its job count.
//   cfg_wr_en/cfg_wr_data set the number of active resources (0 acts as 1,
//   above the built count acts as the built count); write only when idle.
// Sequence:
//   each accepted job is scanned through the shared compare unit one
//   resource per cycle, then the sequencer chooses the resource, updates
//   the tables and ranks the most used resource, and the result is held
//   registered on m_tdata until taken; a new job is not accepted before
//   the last result is taken. s_tready is low from acceptance until the
//   result transaction completes.
// Reset:
//   all free times, counts, current time and most used tracking are zero,
//   the active count is 16. A stalled result simply holds on m_tdata.
// ----------------------------------------------------------------------------
module lowest_free_resource_scheduler
    import lfrs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,   // resources_in_use
    // job input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,       // start_time[31:0], end_time[63:32]
    // result output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata        // assigned_resource[5:0], actual_start[69:6],
                                        // finish_time[133:70],
                                        // most_used_resource[139:134],
                                        // most_used_count[171:140], zero pad
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHOOSE,
        S_WRITE,
        S_BEST,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]     cfg_reg;
    logic [TIME_W-1:0]    free_at_reg   [RESOURCES];
    logic [COUNT_W-1:0]   job_count_reg [RESOURCES];
    logic [TIME_W-1:0]    cur_time_reg;
    logic [RES_W-1:0]     best_index_reg;
    logic [COUNT_W-1:0]   best_count_reg;
    logic [TIME_IN_W-1:0] dur_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     chosen_reg;
    logic [COUNT_W-1:0]   new_count_reg;
    logic [TIME_W-1:0]    finish_reg;
    logic                 m_tvalid_reg;
    logic [175:0]         m_tdata_reg;

    logic [TIME_IN_W-1:0] in_start;
    logic [TIME_IN_W-1:0] in_end;
    logic [TIME_W-1:0]    start_wide;
    logic [IDX_W-1:0]     last_idx;
    logic [COUNT_W-1:0]   old_count;
    logic [RES_W-1:0]     chosen_wide;
    logic                 take_best;
    pick_ctrl_t           pick_ctrl;
    pick_stat_t           pick_stat;

    assign in_start   = s_tdata[31:0];
    assign in_end     = s_tdata[63:32];
    assign start_wide = {{(TIME_W-TIME_IN_W){1'b0}}, in_start};

    // last active resource index, clamped to the built range
    always_comb begin
        priority if (cfg_reg == '0) begin
            last_idx = '0;
        end else if (cfg_reg > CFG_W'(RESOURCES)) begin
            last_idx = IDX_W'(RESOURCES - 1);
        end else begin
            last_idx = IDX_W'(cfg_reg - CFG_W'(1));
        end
    end

    // shared compare unit
    assign pick_ctrl.step  = (state_reg == S_SCAN);
    assign pick_ctrl.first = (scan_idx_reg == '0);

    lfrs_pick u_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (pick_ctrl),
        .idx       (scan_idx_reg),
        .free_time (free_at_reg[scan_idx_reg]),
        .cur_time  (cur_time_reg),
        .stat      (pick_stat)
    );

    // count of the chosen resource and ranking against the best so far
    assign old_count   = job_count_reg[chosen_reg];
    assign chosen_wide = {{(RES_W-IDX_W){1'b0}}, chosen_reg};
    assign take_best   = (new_count_reg > best_count_reg) ||
                         ((new_count_reg == best_count_reg) &&
                          (chosen_wide < best_index_reg));

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // sequencer, tables and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cur_time_reg   <= '0;
            best_index_reg <= '0;
            best_count_reg <= '0;
            scan_idx_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < RESOURCES; i++) begin
                free_at_reg[i]   <= '0;
                job_count_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (start_wide > cur_time_reg) begin
                            cur_time_reg <= start_wide;
                        end
                        dur_reg      <= (in_end >= in_start) ? (in_end - in_start) : '0;
                        scan_idx_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_idx_reg == last_idx) begin
                        state_reg <= S_CHOOSE;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                S_CHOOSE: begin
                    if (pick_stat.found) begin
                        chosen_reg <= pick_stat.chosen;
                    end else begin
                        chosen_reg   <= pick_stat.earliest_idx;
                        cur_time_reg <= pick_stat.earliest_time;
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    finish_reg <= cur_time_reg +
                                  {{(TIME_W-TIME_IN_W){1'b0}}, dur_reg};
                    free_at_reg[chosen_reg] <= cur_time_reg +
                                  {{(TIME_W-TIME_IN_W){1'b0}}, dur_reg};
                    if (old_count != '1) begin
                        job_count_reg[chosen_reg] <= old_count + COUNT_W'(1);
                        new_count_reg             <= old_count + COUNT_W'(1);
                    end else begin
                        new_count_reg <= old_count;
                    end
                    state_reg <= S_BEST;
                end
                S_BEST: begin
                    if (take_best) begin
                        best_index_reg <= chosen_wide;
                        best_count_reg <= new_count_reg;
                    end
                    m_tdata_reg <= {4'b0,
                                    take_best ? new_count_reg : best_count_reg,
                                    take_best ? chosen_wide : best_index_reg,
                                    finish_reg,
                                    cur_time_reg,
                                    chosen_wide};
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lowest free resource scheduler. A directed
// table covers reset behaviour, field extremes, end before start and late
// (out of order) jobs, then random job streams run under several settings of
// the active resource count, including the out-of-range settings. Each
// result transaction is checked field by field against a cycle-free model
// of the scheduler, with random idling on both sides and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import lfrs_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int JOBS_PER_RUN  = 210;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 600;
    localparam int TAIL_CYCLES   = RESOURCES + 14;
    localparam int DIRECTED_JOBS = 10;
    localparam int SETTINGS_N    = 9;

    // one result as packed on m_tdata, lowest field last
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [RES_W-1:0]   most_used;
        logic [TIME_W-1:0]  finish;
        logic [TIME_W-1:0]  act_start;
        logic [RES_W-1:0]   resource;
    } sched_result_t;

    // one row of the directed table
    typedef struct packed {
        logic [TIME_IN_W-1:0] req_start;
        logic [TIME_IN_W-1:0] req_end;
        logic                 typed;
        sched_result_t        want;
    } job_row_t;

    logic         aclk;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [6:0]   cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [175:0] m_tdata;

    // scheduler model state
    logic [TIME_W-1:0]  free_at   [RESOURCES];
    logic [COUNT_W-1:0] job_count [RESOURCES];
    logic [TIME_W-1:0]  cur_time;
    logic [RES_W-1:0]   best_idx;
    logic [COUNT_W-1:0] best_cnt;
    logic [CFG_W-1:0]   active_cfg;

    sched_result_t      pending_results [$];
    logic [TIME_IN_W-1:0] last_start;
    int                 errors = 0;

    // reset behaviour, extremes, end before start and late jobs
    job_row_t directed_jobs [DIRECTED_JOBS] = '{
        '{32'd0, 32'd10, 1'b1, '{32'd1, 6'd0, 64'd10, 64'd0, 6'd0}},
        '{32'd0, 32'd0, 1'b1, '{32'd1, 6'd0, 64'd0, 64'd0, 6'd1}},
        '{32'd5, 32'd3, 1'b1, '{32'd2, 6'd1, 64'd5, 64'd5, 6'd1}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'd2, 6'd0, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 6'd0}},
        '{32'd0, 32'hFFFF_FFFF, 1'b1,
          '{32'd3, 6'd0, 64'h1_FFFF_FFFE, 64'hFFFF_FFFF, 6'd0}},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'd0, 1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0}
    };

    // active counts: single, zero, all ones, mid, built count, above it
    logic [CFG_W-1:0] cfg_values [SETTINGS_N] = '{
        7'd1, 7'd0, 7'd127, 7'd5, 7'd16, 7'd64, 7'd17, 7'd9, 7'd3
    };

    lowest_free_resource_scheduler u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // start_time[31:0], end_time[63:32]
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)       // assigned_resource, actual_start, finish_time,
                                     // most_used_resource, most_used_count, pad
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // clear the model to its reset state
    function automatic void clear_schedule();
        for (int i = 0; i < RESOURCES; i++) begin
            free_at[i]   = '0;
            job_count[i] = '0;
        end
        cur_time   = '0;
        best_idx   = '0;
        best_cnt   = '0;
        active_cfg = CFG_RESET;
    endfunction

    // place one job on a resource and return the resulting schedule entry
    function automatic sched_result_t schedule_job(input logic [TIME_IN_W-1:0] req_start,
                                                   input logic [TIME_IN_W-1:0] req_end);
        sched_result_t     res;
        logic [TIME_W-1:0] dur;
        int                n;
        int                chosen;
        int                earliest;
        bit                found;
        dur      = (req_end >= req_start) ? TIME_W'(req_end - req_start) : '0;
        n        = int'(active_cfg);
        chosen   = 0;
        earliest = 0;
        found    = 1'b0;
        if (n < 1) n = 1;
        if (n > RESOURCES) n = RESOURCES;
        if (TIME_W'(req_start) > cur_time) cur_time = TIME_W'(req_start);
        // lowest resource free by now, and the earliest free one
        for (int i = 0; i < n; i++) begin
            if (!found && free_at[i] <= cur_time) begin
                chosen = i;
                found  = 1'b1;
            end
            if (free_at[i] < free_at[earliest]) earliest = i;
        end
        // all busy: wait for the earliest one
        if (!found) begin
            chosen   = earliest;
            cur_time = free_at[earliest];
        end
        free_at[chosen] = cur_time + dur;
        if (job_count[chosen] != '1) job_count[chosen]++;
        if (job_count[chosen] > best_cnt ||
            (job_count[chosen] == best_cnt && RES_W'(chosen) < best_idx)) begin
            best_idx = RES_W'(chosen);
            best_cnt = job_count[chosen];
        end
        res.resource  = RES_W'(chosen);
        res.act_start = cur_time;
        res.finish    = free_at[chosen];
        res.most_used = best_idx;
        res.count     = best_cnt;
        return res;
    endfunction

    // random job: mostly rising starts with short work, some noise
    task automatic next_job(output logic [TIME_IN_W-1:0] req_start,
                            output logic [TIME_IN_W-1:0] req_end);
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
            req_start = last_start + $urandom_range(0, 6);
            req_end   = req_start + $urandom_range(0, 120);
        end else if (mode < 80) begin
            req_start = last_start + $urandom_range(0, 4000);
            req_end   = req_start + $urandom;
        end else if (mode < 88) begin
            req_start = last_start + $urandom_range(0, 50);
            req_end   = req_start - $urandom_range(1, 1000);
        end else if (mode < 96) begin
            req_start = $urandom;
            req_end   = $urandom;
        end else begin
            req_start = last_start;
            req_end   = '1;
        end
        last_start = req_start;
    endtask

    // offer one job and record its expected result on acceptance
    int  s_items = 0;
    bit  s_calm  = 1'b0;
    task automatic send_job(input logic [TIME_IN_W-1:0] req_start,
                            input logic [TIME_IN_W-1:0] req_end,
                            input logic typed, input sched_result_t want);
        int            gap;
        sched_result_t res;
        if (s_items % 40 == 0) s_calm = ($urandom_range(0, 3) == 0);
        gap = s_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req_end, req_start};
        do @(posedge aclk); while (!s_tready);
        res = schedule_job(req_start, req_end);
        pending_results.push_back(typed ? want : res);
        s_items++;
    endtask

    // stop offering and wait for the block to go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        active_cfg  = value;
    endtask

    task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // check one result transaction against the oldest expectation
    task automatic check_result(input sched_result_t got);
        sched_result_t want;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
        end else begin
            want = pending_results.pop_front();
            compare_field("assigned_resource", TIME_W'(want.resource), TIME_W'(got.resource));
            compare_field("actual_start", want.act_start, got.act_start);
            compare_field("finish_time", want.finish, got.finish);
            compare_field("most_used_resource", TIME_W'(want.most_used),
                          TIME_W'(got.most_used));
            compare_field("most_used_count", TIME_W'(want.count), TIME_W'(got.count));
        end
    endtask

    // result side: random stalls and one long hold-off
    initial begin
        int gap;
        int got;
        bit calm;
        bit held;
        got  = 0;
        calm = 1'b0;
        held = 1'b0;
        forever begin
            if (got % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 18);
            if (!held && got == HOLD_AT) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            check_result(sched_result_t'(m_tdata[171:0]));
            got++;
        end
    end

    // run limit
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("lowest_free_resource_scheduler verification failed");
        $finish;
    end

    // job side: reset, directed table, then one random run per setting
    initial begin
        logic [TIME_IN_W-1:0] req_start;
        logic [TIME_IN_W-1:0] req_end;
        clear_schedule();
        last_start = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_JOBS; r++) begin
            send_job(directed_jobs[r].req_start, directed_jobs[r].req_end,
                     directed_jobs[r].typed, directed_jobs[r].want);
        end

        for (int p = 0; p < SETTINGS_N; p++) begin
            drain();
            write_cfg(cfg_values[p]);
            for (int k = 0; k < JOBS_PER_RUN; k++) begin
                next_job(req_start, req_end);
                send_job(req_start, req_end, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("lowest_free_resource_scheduler verification clean");
        end else begin
            $display("lowest_free_resource_scheduler verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/lfrs_pkg.sv
hdl/lfrs_pick.sv
hdl/lowest_free_resource_scheduler.sv
test/tb_top.sv
